// File: hw/rtl/zsep_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zsep_pkg
// shared types and constants of the stored-entry zip parser
// ----------------------------------------------------------------------------
package zsep_pkg;

    // local file header layout
    localparam logic [31:0] SIG_LOCAL_HEADER = 32'h04034b50;
    localparam int          HEADER_BYTES     = 30;
    localparam logic [4:0]  OFS_SIG_LAST     = 5'd3;
    localparam logic [4:0]  OFS_METHOD_LO    = 5'd8;
    localparam logic [4:0]  OFS_METHOD_HI    = 5'd9;
    localparam logic [4:0]  OFS_SIZE_FIRST   = 5'd18;
    localparam logic [4:0]  OFS_SIZE_LAST    = 5'd21;
    localparam logic [4:0]  OFS_NAME_LO      = 5'd26;
    localparam logic [4:0]  OFS_NAME_HI      = 5'd27;
    localparam logic [4:0]  OFS_EXTRA_LO     = 5'd28;
    localparam logic [4:0]  OFS_HEADER_LAST  = 5'(HEADER_BYTES - 1);

    localparam logic [15:0] METHOD_STORED    = 16'd0;
    localparam logic [7:0]  SLASH_CHAR       = 8'h2F;

    // depth of the queue between parser and output stage
    localparam int          QUEUE_DEPTH      = 4;

    typedef enum logic [2:0] {
        KIND_NAME    = 3'd0,
        KIND_DATA    = 3'd1,
        KIND_KEPT    = 3'd2,
        KIND_DROPPED = 3'd3,
        KIND_TRUNC   = 3'd4
    } kind_t;

    // results caused by one archive byte: one or two, the second always a marker
    typedef struct packed {
        logic       two;
        kind_t      kind_a;
        logic [7:0] byte_a;
        kind_t      kind_b;
    } result_pair_t;

endpackage
`default_nettype wire

// File: hw/rtl/zip_stored_entry_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zip_stored_entry_parser
// streaming parser of zip local entries that passes out stored entries
// ----------------------------------------------------------------------------
// The archive comes in one byte per item transfer, with end_of_archive on its
// final byte. Each 30-byte local header is parsed at the standard offsets; for
// a stored entry the name bytes and then the data bytes come out, followed by
// a kept marker, or a dropped marker when the name is empty or ends in '/'.
// Compressed entries are skipped silently, a bad signature silences the parser
// until the end of the archive, and an archive that stops in the name, extra
// field or data of a stored entry closes with a truncated marker. The parser
// takes one byte per cycle while its result queue (QUEUE_DEPTH pairs) has
// room; the output register sends one result per cycle when not stalled, so
// a byte that causes two results (its own byte plus a marker) takes two
// transfers; name and data runs sustain one byte per cycle without stalls.
// ----------------------------------------------------------------------------
module zip_stored_entry_parser
#(
    parameter int QUEUE_DEPTH = zsep_pkg::QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // archive byte channel
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_archive,
    // result channel
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic [2:0]      kind,
    output logic [7:0]      out_byte,
    output logic            run_last
);

    // front to queue
    logic                   push;
    zsep_pkg::result_pair_t push_entry;
    logic                   queue_full;

    // queue to back
    logic                   queue_empty;
    zsep_pkg::result_pair_t queue_head;
    logic                   pop;

    // header parsing and phase tracking, one archive byte per transfer
    zsep_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .data_byte      (data_byte),
        .end_of_archive (end_of_archive),
        .queue_full     (queue_full),
        .push           (push),
        .push_entry     (push_entry)
    );

    // decouples the parser from stalls on the result side
    zsep_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .empty      (queue_empty),
        .head       (queue_head)
    );

    // output register, one result transfer at a time
    zsep_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (queue_empty),
        .head         (queue_head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .out_byte     (out_byte),
        .run_last     (run_last)
    );

endmodule
`default_nettype wire

// File: hw/rtl/zsep_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zsep_front
// header parser: tracks the entry phase and classifies each byte
// ----------------------------------------------------------------------------
module zsep_front
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  end_of_archive,
    input  wire logic                  queue_full,
    output logic                       push,
    output zsep_pkg::result_pair_t     push_entry
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME,
        PH_EXTRA,
        PH_DATA,
        PH_HALT
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  hidx_reg, hidx_next;
    logic [31:0] sig_reg, sig_next;
    logic [15:0] meth_reg, meth_next;
    logic [31:0] drem_reg, drem_next;
    logic [15:0] nrem_reg, nrem_next;
    logic [15:0] erem_reg, erem_next;
    logic [7:0]  fnc_reg, fnc_next;

    logic                  accept;
    logic                  adv;
    logic                  byte_res;
    zsep_pkg::kind_t       byte_kind;
    logic                  stored;
    logic [1:0]            cnt;
    zsep_pkg::result_pair_t entry;

    assign item_stall = queue_full;
    assign accept     = item_valid && !queue_full;

    always_comb
    begin
        phase_next = phase_reg;
        hidx_next  = hidx_reg;
        sig_next   = sig_reg;
        meth_next  = meth_reg;
        drem_next  = drem_reg;
        nrem_next  = nrem_reg;
        erem_next  = erem_reg;
        fnc_next   = fnc_reg;
        adv        = 1'b0;
        byte_res   = 1'b0;
        byte_kind  = zsep_pkg::KIND_NAME;
        cnt        = 2'd0;
        entry      = '0;

        if (accept)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (hidx_reg <= zsep_pkg::OFS_SIG_LAST)
                    begin
                        sig_next = {data_byte, sig_reg[31:8]};
                        if (hidx_reg == zsep_pkg::OFS_SIG_LAST
                            && sig_next != zsep_pkg::SIG_LOCAL_HEADER)
                        begin
                            phase_next = PH_HALT;
                        end
                    end
                    else if (hidx_reg == zsep_pkg::OFS_METHOD_LO)
                    begin
                        meth_next = {8'd0, data_byte};
                    end
                    else if (hidx_reg == zsep_pkg::OFS_METHOD_HI)
                    begin
                        meth_next = {data_byte, meth_reg[7:0]};
                    end
                    else if (hidx_reg >= zsep_pkg::OFS_SIZE_FIRST
                             && hidx_reg <= zsep_pkg::OFS_SIZE_LAST)
                    begin
                        drem_next = {data_byte, drem_reg[31:8]};
                    end
                    else if (hidx_reg == zsep_pkg::OFS_NAME_LO)
                    begin
                        nrem_next = {8'd0, data_byte};
                    end
                    else if (hidx_reg == zsep_pkg::OFS_NAME_HI)
                    begin
                        nrem_next = {data_byte, nrem_reg[7:0]};
                    end
                    else if (hidx_reg == zsep_pkg::OFS_EXTRA_LO)
                    begin
                        erem_next = {8'd0, data_byte};
                    end
                    else if (hidx_reg == zsep_pkg::OFS_HEADER_LAST)
                    begin
                        erem_next = {data_byte, erem_reg[7:0]};
                    end

                    if (phase_next == PH_HEADER)
                    begin
                        if (hidx_reg >= zsep_pkg::OFS_HEADER_LAST)
                        begin
                            fnc_next  = 8'd0;
                            hidx_next = {4'd0, (nrem_next != 16'd0)};
                            adv       = 1'b1;
                        end
                        else
                        begin
                            hidx_next = hidx_reg + 5'd1;
                        end
                    end
                end
                PH_NAME:
                begin
                    nrem_next = nrem_reg - 16'd1;
                    fnc_next  = data_byte;
                    byte_res  = 1'b1;
                    byte_kind = zsep_pkg::KIND_NAME;
                    adv       = (nrem_next == 16'd0);
                end
                PH_EXTRA:
                begin
                    erem_next = erem_reg - 16'd1;
                    adv       = (erem_next == 16'd0);
                end
                PH_DATA:
                begin
                    drem_next = drem_reg - 32'd1;
                    byte_res  = 1'b1;
                    byte_kind = zsep_pkg::KIND_DATA;
                    adv       = (drem_next == 32'd0);
                end
                default:
                begin
                    // halted: bytes are ignored until the end of the archive
                end
            endcase
        end

        stored = (meth_next == zsep_pkg::METHOD_STORED);

        if (byte_res && stored)
        begin
            entry.kind_a = byte_kind;
            entry.byte_a = data_byte;
            cnt          = 2'd1;
        end

        // step to the next non-empty part of the entry, or finish it
        if (adv)
        begin
            if (nrem_next != 16'd0)
            begin
                phase_next = PH_NAME;
            end
            else if (erem_next != 16'd0)
            begin
                phase_next = PH_EXTRA;
            end
            else if (drem_next != 32'd0)
            begin
                phase_next = PH_DATA;
            end
            else
            begin
                if (stored)
                begin
                    if (cnt == 2'd0)
                    begin
                        entry.kind_a = (hidx_next == 5'd0 || fnc_next == zsep_pkg::SLASH_CHAR)
                                       ? zsep_pkg::KIND_DROPPED : zsep_pkg::KIND_KEPT;
                        cnt = 2'd1;
                    end
                    else
                    begin
                        entry.kind_b = (hidx_next == 5'd0 || fnc_next == zsep_pkg::SLASH_CHAR)
                                       ? zsep_pkg::KIND_DROPPED : zsep_pkg::KIND_KEPT;
                        cnt = 2'd2;
                    end
                end
                phase_next = PH_HEADER;
                hidx_next  = 5'd0;
            end
        end

        if (accept && end_of_archive)
        begin
            if ((phase_next == PH_NAME || phase_next == PH_EXTRA || phase_next == PH_DATA)
                && stored)
            begin
                if (cnt == 2'd0)
                begin
                    entry.kind_a = zsep_pkg::KIND_TRUNC;
                    cnt = 2'd1;
                end
                else
                begin
                    entry.kind_b = zsep_pkg::KIND_TRUNC;
                    cnt = 2'd2;
                end
            end
            phase_next = PH_HEADER;
            hidx_next  = 5'd0;
            sig_next   = 32'd0;
            meth_next  = 16'd0;
            drem_next  = 32'd0;
            nrem_next  = 16'd0;
            erem_next  = 16'd0;
            fnc_next   = 8'd0;
        end

        entry.two = cnt[1];
    end

    assign push       = accept && (cnt != 2'd0);
    assign push_entry = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hidx_reg  <= 5'd0;
            sig_reg   <= 32'd0;
            meth_reg  <= 16'd0;
            drem_reg  <= 32'd0;
            nrem_reg  <= 16'd0;
            erem_reg  <= 16'd0;
            fnc_reg   <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            hidx_reg  <= hidx_next;
            sig_reg   <= sig_next;
            meth_reg  <= meth_next;
            drem_reg  <= drem_next;
            nrem_reg  <= nrem_next;
            erem_reg  <= erem_next;
            fnc_reg   <= fnc_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/zsep_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zsep_queue
// short fifo of result pairs between parser and output stage
// ----------------------------------------------------------------------------
module zsep_queue
#(
    parameter int DEPTH = zsep_pkg::QUEUE_DEPTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire zsep_pkg::result_pair_t push_entry,
    input  wire logic                   pop,
    output logic                        full,
    output logic                        empty,
    output zsep_pkg::result_pair_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    zsep_pkg::result_pair_t slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/zsep_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zsep_back
// output stage: serialises each result pair into single result transfers
// ----------------------------------------------------------------------------
module zsep_back
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   empty,
    input  wire zsep_pkg::result_pair_t head,
    output logic                        pop,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output logic [2:0]                  kind,
    output logic [7:0]                  out_byte,
    output logic                        run_last
);

    logic       valid_reg, valid_next;
    logic       second_reg, second_next;
    logic [2:0] kind_reg, kind_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       load;

    assign load = !empty && (!valid_reg || !result_stall);

    always_comb
    begin
        valid_next  = valid_reg && result_stall;
        second_next = second_reg;
        kind_next   = kind_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        pop         = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            if (second_reg)
            begin
                kind_next   = head.kind_b;
                byte_next   = 8'd0;
                last_next   = 1'b1;
                second_next = 1'b0;
                pop         = 1'b1;
            end
            else
            begin
                kind_next   = head.kind_a;
                byte_next   = head.byte_a;
                last_next   = !head.two;
                second_next = head.two;
                pop         = !head.two;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign out_byte     = byte_reg;
    assign run_last     = last_reg;

endmodule
`default_nettype wire
